### design/fjks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjks_pkg
// Types and character constants shared by the flat key/integer scanner.
// ----------------------------------------------------------------------------
package fjks_pkg;

   typedef enum logic [2:0] {
      PH_BRACE = 3'd0,
      PH_QUOTE = 3'd1,
      PH_KEY   = 3'd2,
      PH_COLON = 3'd3,
      PH_VALUE = 3'd4,
      PH_DONE  = 3'd5
   } scan_phase_type;

   typedef enum logic [1:0] {
      VP_SKIP   = 2'd0,
      VP_DIGITS = 2'd1,
      VP_STOP   = 2'd2
   } value_phase_type;

   typedef enum logic [1:0] {
      CTL_SCAN = 2'd0,
      CTL_READ = 2'd1,
      CTL_OUT  = 2'd2
   } ctl_state_type;

   localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
   localparam logic [7:0] CH_QUOTE       = 8'h22;
   localparam logic [7:0] CH_COLON       = 8'h3A;
   localparam logic [7:0] CH_COMMA       = 8'h2C;
   localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
   localparam logic [7:0] CH_PLUS        = 8'h2B;
   localparam logic [7:0] CH_MINUS       = 8'h2D;
   localparam logic [7:0] CH_SPACE       = 8'h20;
   localparam logic [7:0] CH_TAB         = 8'h09;
   localparam logic [7:0] CH_CR          = 8'h0D;
   localparam logic [7:0] CH_DIGIT_0     = 8'h30;
   localparam logic [7:0] CH_DIGIT_9     = 8'h39;

   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

endpackage

### design/fjks_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjks_req_if
// Input byte channel: valid/ready handshake with one text byte.
// ----------------------------------------------------------------------------
interface fjks_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

### design/fjks_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjks_rsp_if
// Result channel: one key byte per transaction, value on the last one.
// ----------------------------------------------------------------------------
interface fjks_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         key_char;
   logic               key_char_valid;
   logic signed [31:0] pair_value;
   logic               key_truncated;
   logic               value_clipped;
   logic               last_of_pair;

   modport source (output valid, output key_char, output key_char_valid,
                   output pair_value, output key_truncated, output value_clipped,
                   output last_of_pair, input ready);
   modport sink (input valid, input key_char, input key_char_valid,
                 input pair_value, input key_truncated, input value_clipped,
                 input last_of_pair, output ready);
endinterface

### design/fjks_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjks_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fjks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 10,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/flat_json_key_int_scanner.sv
`timescale 1ns / 1ps
// A closing ',' or '}' starts a readout of the key buffer RAM: for each key
// byte a RAM read, then an output register load that waits while the result
// channel stalls; there is at least one result, and no input byte is taken
// until the readout ends.
// Reset: synchronous; clears phases, counts, flags and the output valid.
// ----------------------------------------------------------------------------
// flat_json_key_int_scanner
// Scans a flat object of quoted keys with integer values, one byte per
// transaction, and emits each key as a run of results ending with its value.
// The key buffer RAM is not cleared; only written entries ever reach the output.
// ----------------------------------------------------------------------------
module flat_json_key_int_scanner #(
   parameter int MAX_CHARS = 10
) (
   input logic       clock,
   input logic       reset,
   fjks_req_if.sink  req_chan,
   fjks_rsp_if.source rsp_chan
);
   import fjks_pkg::*;

   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHARS);

   scan_phase_type  phase_ff, phase_in;
   value_phase_type vphase_ff, vphase_in;
   ctl_state_type   ctl_state_ff, ctl_state_in;

   logic [CW-1:0] key_count_ff, key_count_in;
   logic [CW-1:0] vcount_ff, vcount_in;
   logic [CW-1:0] emit_idx_ff, emit_idx_in;
   logic          value_neg_ff, value_neg_in;
   logic [31:0]   mag_ff, mag_in;
   logic          key_ovf_ff, key_ovf_in;
   logic          value_ovf_ff, value_ovf_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff;
   logic          rsp_char_valid_ff;
   logic [31:0]   rsp_value_ff;
   logic          rsp_trunc_ff;
   logic          rsp_clip_ff;
   logic          rsp_last_ff;

   logic          req_fire;
   logic          start_emit;
   logic          emit_done;
   logic          out_load;
   logic          emit_last;
   logic          rd_en;
   logic          wr_en;
   logic [7:0]    rd_data;
   logic [7:0]    byte_c;
   logic          is_digit;
   logic          is_space;
   logic [35:0]   mag_ext;
   logic [35:0]   prod;
   logic [31:0]   value_final;
   logic          value_sat;
   logic [CW-1:0] emit_count;

   fjks_ram #(
      .WIDTH(8),
      .DEPTH(MAX_CHARS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(key_count_ff[AW-1:0]),
      .wr_data(byte_c),
      .rd_en  (rd_en),
      .rd_addr(emit_idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign req_chan.ready = (ctl_state_ff == CTL_SCAN);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign byte_c         = req_chan.byte_in;

   assign is_digit = (byte_c >= CH_DIGIT_0) && (byte_c <= CH_DIGIT_9);
   assign is_space = (byte_c == CH_SPACE) || ((byte_c >= CH_TAB) && (byte_c <= CH_CR));
   assign mag_ext  = {4'd0, mag_ff};
   assign prod     = (mag_ext << 3) + (mag_ext << 1) + {32'd0, byte_c[3:0]};

   // final value: negate the magnitude, or saturate a positive overflow
   always_comb begin
      value_sat = 1'b0;
      if (value_neg_ff) begin
         value_final = 32'd0 - mag_ff;
      end else if (mag_ff > POS_MAX) begin
         value_final = POS_MAX;
         value_sat   = 1'b1;
      end else begin
         value_final = mag_ff;
      end
   end

   assign emit_count = (key_count_ff != '0) ? key_count_ff : CW'(1);
   assign emit_last  = ((emit_idx_ff + CW'(1)) == emit_count);
   assign out_load   = (ctl_state_ff == CTL_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // scan datapath
   always_comb begin
      phase_in     = phase_ff;
      vphase_in    = vphase_ff;
      key_count_in = key_count_ff;
      vcount_in    = vcount_ff;
      value_neg_in = value_neg_ff;
      mag_in       = mag_ff;
      key_ovf_in   = key_ovf_ff;
      value_ovf_in = value_ovf_ff;
      wr_en        = 1'b0;
      start_emit   = 1'b0;

      if (req_fire) begin
         case (phase_ff)
            PH_BRACE: begin
               if (byte_c == CH_BRACE_OPEN) phase_in = PH_QUOTE;
            end
            PH_QUOTE: begin
               if (byte_c == CH_QUOTE) phase_in = PH_KEY;
            end
            PH_KEY: begin
               if (byte_c == CH_QUOTE) begin
                  phase_in = PH_COLON;
               end else if (key_count_ff < MAX_CNT) begin
                  wr_en        = 1'b1;
                  key_count_in = key_count_ff + CW'(1);
               end else begin
                  key_ovf_in = 1'b1;
               end
            end
            PH_COLON: begin
               if (byte_c == CH_COLON) phase_in = PH_VALUE;
            end
            PH_VALUE: begin
               if (byte_c == CH_COMMA || byte_c == CH_BRACE_CLOSE) begin
                  // hold pair state until the readout finishes
                  start_emit = 1'b1;
                  phase_in   = (byte_c == CH_COMMA) ? PH_QUOTE : PH_DONE;
               end else if (vcount_ff >= MAX_CNT) begin
                  value_ovf_in = 1'b1;
               end else begin
                  vcount_in = vcount_ff + CW'(1);
                  case (vphase_ff)
                     VP_SKIP: begin
                        if (is_space) begin
                           vphase_in = VP_SKIP;
                        end else if (byte_c == CH_PLUS || byte_c == CH_MINUS) begin
                           value_neg_in = (byte_c == CH_MINUS);
                           vphase_in    = VP_DIGITS;
                        end else if (is_digit) begin
                           vphase_in = VP_DIGITS;
                           if (prod > {4'd0, MAG_LIMIT}) begin
                              mag_in       = MAG_LIMIT;
                              value_ovf_in = 1'b1;
                           end else begin
                              mag_in = prod[31:0];
                           end
                        end else begin
                           vphase_in = VP_STOP;
                        end
                     end
                     VP_DIGITS: begin
                        if (is_digit) begin
                           if (prod > {4'd0, MAG_LIMIT}) begin
                              mag_in       = MAG_LIMIT;
                              value_ovf_in = 1'b1;
                           end else begin
                              mag_in = prod[31:0];
                           end
                        end else begin
                           vphase_in = VP_STOP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end

      // drop the pair once its last result is loaded
      if (emit_done) begin
         vphase_in    = VP_SKIP;
         key_count_in = '0;
         vcount_in    = '0;
         value_neg_in = 1'b0;
         mag_in       = '0;
         key_ovf_in   = 1'b0;
         value_ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= CTL_SCAN;
      end else begin
         ctl_state_ff <= ctl_state_in;
      end
   end

   // readout sequencer
   always_comb begin
      ctl_state_in = ctl_state_ff;
      emit_idx_in  = emit_idx_ff;
      rd_en        = 1'b0;
      emit_done    = 1'b0;
      case (ctl_state_ff)
         CTL_SCAN: begin
            if (start_emit) begin
               ctl_state_in = CTL_READ;
               emit_idx_in  = '0;
            end
         end
         CTL_READ: begin
            rd_en        = 1'b1;
            ctl_state_in = CTL_OUT;
         end
         CTL_OUT: begin
            if (out_load) begin
               if (emit_last) begin
                  emit_done    = 1'b1;
                  ctl_state_in = CTL_SCAN;
               end else begin
                  emit_idx_in  = emit_idx_ff + CW'(1);
                  ctl_state_in = CTL_READ;
               end
            end
         end
         default: begin
            ctl_state_in = CTL_SCAN;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BRACE;
         vphase_ff    <= VP_SKIP;
         key_count_ff <= '0;
         vcount_ff    <= '0;
         emit_idx_ff  <= '0;
         value_neg_ff <= 1'b0;
         mag_ff       <= '0;
         key_ovf_ff   <= 1'b0;
         value_ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         vphase_ff    <= vphase_in;
         key_count_ff <= key_count_in;
         vcount_ff    <= vcount_in;
         emit_idx_ff  <= emit_idx_in;
         value_neg_ff <= value_neg_in;
         mag_ff       <= mag_in;
         key_ovf_ff   <= key_ovf_in;
         value_ovf_ff <= value_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_char_ff       <= (key_count_ff != '0) ? rd_data : 8'd0;
         rsp_char_valid_ff <= (key_count_ff != '0);
         rsp_value_ff      <= emit_last ? value_final : 32'd0;
         rsp_trunc_ff      <= key_ovf_ff;
         rsp_clip_ff       <= value_ovf_ff | value_sat;
         rsp_last_ff       <= emit_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.key_char       = rsp_char_ff;
   assign rsp_chan.key_char_valid = rsp_char_valid_ff;
   assign rsp_chan.pair_value     = $signed(rsp_value_ff);
   assign rsp_chan.key_truncated  = rsp_trunc_ff;
   assign rsp_chan.value_clipped  = rsp_clip_ff;
   assign rsp_chan.last_of_pair   = rsp_last_ff;

   a_key_count_bound: assert property (@(posedge clock) disable iff (reset)
      (key_count_ff <= MAX_CNT) && (vcount_ff <= MAX_CNT))
      else $error("pair counter past buffer size");

   a_emit_from_value: assert property (@(posedge clock) disable iff (reset)
      (ctl_state_ff == CTL_SCAN && ctl_state_in == CTL_READ) |=>
         (phase_ff == PH_QUOTE || phase_ff == PH_DONE))
      else $error("readout started outside a value terminator");

   a_pair_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_done |=> (ctl_state_ff == CTL_SCAN && key_count_ff == '0 && mag_ff == '0
                     && rsp_valid_ff && rsp_last_ff))
      else $error("pair state not cleared after last result");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (ctl_state_ff != CTL_SCAN) |-> (emit_idx_ff < emit_count))
      else $error("readout index beyond key length");

endmodule
